FILE: rtl/lbb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the line box blur.
package lbb_pkg;

   localparam int PIX_W    = 8;
   localparam int NUM_CHAN = 3;
   localparam int RADIUS_W = 5;
   localparam int QUOT_W   = 8;
   localparam int STEP_W   = 3;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 5'd14;
   localparam logic [PIX_W-1:0]    ALPHA_VALUE  = 8'd255;

   // Channel 0 is blue, 1 green, 2 red.
   typedef logic [NUM_CHAN-1:0][PIX_W-1:0] rgb_type;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_ADD    = 6'b000010,
      ST_DECIDE = 6'b000100,
      ST_DIV    = 6'b001000,
      ST_PUT    = 6'b010000,
      ST_READ   = 6'b100000
   } state_type;

   typedef struct packed {
      logic accept;
      logic read;
      logic add;
      logic div_start;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic emit;
      logic more;
      logic div_busy;
      logic out_free;
   } status_type;

endpackage

FILE: rtl/line_box_blur.sv
`timescale 1ns / 1ps
// Top level of the horizontal line box blur.
//
// Horizontal box filter over one line of BGR pixels. Each result is the truncated
// per-channel mean over 2r+1 pixels centered on its position, with positions past
// either end of the line taking the edge pixel; alpha is always 255. The radius r is
// csr_wr_data, limited to MAX_RADIUS, and is sampled when the first pixel of a line
// is taken, so a write during a line applies from the next line. Result x leaves once
// pixel x+r is in; the pixel marked by req_tlast (or the one that makes MAX_LINE)
// closes the line and releases the remaining results, the last one with rsp_tlast.
// One pixel is handled at a time: a pixel that yields no result passes only through
// the shared window update (read, add, decide); one that yields a result, and each
// result of the line-end drain, also runs the bit-serial divider for the means,
// waits to see it finish, and hands the result to the output register, which holds
// it while the next pixel is taken. While the output register still holds an
// unaccepted result, the hand-over waits.
module line_box_blur import lbb_pkg::*; #(
   parameter int MAX_RADIUS = 31,
   parameter int MAX_LINE   = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [RADIUS_W-1:0] csr_wr_data,  // radius
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [23:0]         req_tdata,    // blue_in, green_in, red_in
   input  logic                req_tlast,    // line_end_in
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata,    // blue_out, green_out, red_out, alpha_out
   output logic                rsp_tlast     // line_end_out
);

   cmd_type    cmd;
   status_type status;
   rgb_type    rsp_pix;

   lbb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .status     (status),
      .cmd        (cmd),
      .ready      (req_tready)
   );

   lbb_dp #(
      .MAX_RADIUS (MAX_RADIUS),
      .MAX_LINE   (MAX_LINE)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_pix     (rgb_type'(req_tdata)),
      .req_last    (req_tlast),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_pix     (rsp_pix),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tdata = {ALPHA_VALUE, rsp_pix};

`ifndef SYNTH
   a_accept_div_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> !status.div_busy)
      else $error("pixel transfer while the divider is running");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> status.out_free)
      else $error("result loaded over one still waiting");

   a_accept_then_add: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> cmd.add)
      else $error("pixel transfer not followed by window update");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> status.div_busy)
      else $error("divider did not start");
`endif

endmodule

FILE: rtl/lbb_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for one channel mean.
module lbb_div import lbb_pkg::*; #(
   parameter int DVD_W = 14,
   parameter int DVS_W = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DVD_W-1:0]  dividend,
   input  logic [DVS_W-1:0]  divisor,
   output logic              busy,
   output logic [QUOT_W-1:0] quotient
);

   localparam int CMP_W = DVD_W + DVS_W + QUOT_W;

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DVD_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [CMP_W-1:0]  trial;
   logic              fits;

   always_comb begin
      trial   = CMP_W'(dvs_ff) << step_ff;
      fits    = CMP_W'(rem_ff) >= trial;
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(QUOT_W - 1);
         rem_in  = dividend;
         dvs_in  = divisor;
         quot_in = '0;
      end else if (busy_ff) begin
         // quotient is known to fit QUOT_W bits, so start at the top bit
         if (fits) begin
            rem_in           = rem_ff - trial[DVD_W-1:0];
            quot_in[step_ff] = 1'b1;
         end
         step_in = step_ff - 1'b1;
         busy_in = (step_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quot_ff <= quot_in;
   end

   assign busy     = busy_ff;
   assign quotient = quot_ff;

endmodule

FILE: rtl/lbb_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the line box blur: arrival, window update, divide, result transfer.
module lbb_ctrl import lbb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  status_type status,
   output cmd_type    cmd,
   output logic       ready
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      ready    = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_ADD;
            end
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (status.emit) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else if (status.more) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (!status.div_busy) begin
               state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            // hold until the output register can take the result
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = status.more ? ST_READ : ST_IDLE;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_ADD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/lbb_dp.sv
`timescale 1ns / 1ps
// Datapath of the line box blur: pixel store, running sums, dividers, output register.
module lbb_dp import lbb_pkg::*; #(
   parameter int MAX_RADIUS = 31,
   parameter int MAX_LINE   = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic                csr_wr_en,
   input  logic [RADIUS_W-1:0] csr_wr_data,
   input  rgb_type             req_pix,
   input  logic                req_last,
   input  logic                rsp_tready,
   output logic                rsp_tvalid,
   output rgb_type             rsp_pix,
   output logic                rsp_last
);

   localparam int RAD_W    = $clog2(MAX_RADIUS + 1);
   localparam int DIAM_W   = RAD_W + 1;
   localparam int ADDR_W   = $clog2(2 * MAX_RADIUS + 2);
   localparam int DEPTH    = 2 ** ADDR_W;
   localparam int IDX_W    = $clog2(MAX_LINE);
   localparam int HEAD_RAW = $clog2(MAX_LINE + MAX_RADIUS);
   localparam int HEAD_W   = (HEAD_RAW > DIAM_W) ? HEAD_RAW : DIAM_W;
   localparam int SUM_W    = $clog2((2 * MAX_RADIUS + 1) * 255 + 1);

   rgb_type store_mem [DEPTH];

   logic [RADIUS_W-1:0] radius_ff, radius_in;
   logic [RAD_W-1:0]    lr_ff, lr_in;
   logic [IDX_W-1:0]    p_ff, p_in;
   logic [IDX_W-1:0]    last_ff, last_in;
   logic                first_ff, first_in;
   logic                end_ff, end_in;
   logic [HEAD_W-1:0]   head_ff, head_in;
   rgb_type             pix_ff, pix_in;
   rgb_type             rd_ff;
   logic [SUM_W-1:0]    sum_ff [NUM_CHAN];
   logic [SUM_W-1:0]    sum_in [NUM_CHAN];
   logic                rsp_valid_ff, rsp_valid_in;
   rgb_type             rsp_pix_ff;
   logic                rsp_last_ff;

   logic [RAD_W-1:0]    eff_radius;
   logic [DIAM_W-1:0]   diam;
   logic [HEAD_W-1:0]   span;
   logic [ADDR_W-1:0]   rd_addr;
   logic [ADDR_W-1:0]   wr_addr;
   logic                at_end;
   logic                line_end;
   rgb_type             quot;
   logic [NUM_CHAN-1:0] busy_vec;

   always_comb begin
      eff_radius = (int'(radius_ff) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(radius_ff);
      diam       = {lr_ff, 1'b1};
      span       = HEAD_W'({lr_ff, 1'b0});
      // oldest pixel of the window, clamped to the line start
      rd_addr    = (head_ff < span) ? '0 : ADDR_W'(head_ff - span);
      wr_addr    = ADDR_W'(p_ff);
      at_end     = (head_ff == HEAD_W'(last_ff) + HEAD_W'(lr_ff));
      line_end   = req_last || (p_ff == IDX_W'(MAX_LINE - 1));

      status.emit     = (head_ff >= HEAD_W'(lr_ff));
      status.more     = end_ff && !at_end;
      status.div_busy = |busy_vec;
      status.out_free = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      radius_in = csr_wr_en ? csr_wr_data : radius_ff;
      lr_in     = lr_ff;
      p_in      = p_ff;
      last_in   = last_ff;
      first_in  = first_ff;
      end_in    = end_ff;
      head_in   = head_ff;
      pix_in    = pix_ff;
      for (int c = 0; c < NUM_CHAN; c++) begin
         sum_in[c] = sum_ff[c];
      end
      if (cmd.accept) begin
         pix_in   = req_pix;
         first_in = (p_ff == '0);
         end_in   = line_end;
         last_in  = p_ff;
         p_in     = line_end ? '0 : p_ff + 1'b1;
         if (p_ff == '0) begin
            lr_in = eff_radius;
         end
      end
      if (cmd.add) begin
         // drop the oldest pixel, add the newest (the last pixel while draining)
         for (int c = 0; c < NUM_CHAN; c++) begin
            if (first_ff) begin
               sum_in[c] = SUM_W'(diam) * SUM_W'(pix_ff[c]);
            end else begin
               sum_in[c] = sum_ff[c] - SUM_W'(rd_ff[c]) + SUM_W'(pix_ff[c]);
            end
         end
         head_in  = first_ff ? '0 : head_ff + 1'b1;
         first_in = 1'b0;
      end
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         store_mem[wr_addr] <= req_pix;
      end
      if (cmd.accept || cmd.read) begin
         rd_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff    <= RADIUS_RESET;
         p_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         radius_ff    <= radius_in;
         p_ff         <= p_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lr_ff    <= lr_in;
      last_ff  <= last_in;
      first_ff <= first_in;
      end_ff   <= end_in;
      head_ff  <= head_in;
      pix_ff   <= pix_in;
      for (int c = 0; c < NUM_CHAN; c++) begin
         sum_ff[c] <= sum_in[c];
      end
      if (cmd.load) begin
         rsp_pix_ff  <= quot;
         rsp_last_ff <= end_ff && at_end;
      end
   end

   for (genvar c = 0; c < NUM_CHAN; c++) begin : g_div
      lbb_div #(
         .DVD_W (SUM_W),
         .DVS_W (DIAM_W)
      ) u_div (
         .clock    (clock),
         .reset    (reset),
         .start    (cmd.div_start),
         .dividend (sum_ff[c]),
         .divisor  (diam),
         .busy     (busy_vec[c]),
         .quotient (quot[c])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_pix    = rsp_pix_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

FILE: dv/line_box_blur_checker.sv
`timescale 1ns / 1ps
// Checker for the line box blur: predicts every output pixel and compares the transfers.
module line_box_blur_checker import lbb_pkg::*; #(
   parameter int MAX_RADIUS = 31,
   parameter int MAX_LINE   = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [RADIUS_W-1:0] csr_wr_data,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [23:0]         req_tdata,    // blue_in, green_in, red_in
   input  logic                req_tlast,    // line_end_in
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [31:0]         rsp_tdata,    // blue_out, green_out, red_out, alpha_out
   input  logic                rsp_tlast,    // line_end_out
   output int                  fail_count,
   output int                  pending_count
);

   localparam int STORE_DEPTH  = 64;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic             line_end;
      logic [PIX_W-1:0] alpha;
      rgb_type          mean;
   } blur_pixel_type;

   logic [RADIUS_W-1:0] radius_reg = RADIUS_RESET;
   int unsigned         line_radius = RADIUS_RESET;
   rgb_type             line_pixels [STORE_DEPTH];
   int unsigned         pixels_in  = 0;
   int unsigned         pixels_out = 0;
   int                  fail_total = 0;
   blur_pixel_type      blurred_q [$];

   // Mean over the window centered on one position, edges clamped to the line.
   function automatic blur_pixel_type window_mean(int unsigned center, int unsigned count,
                                                  logic closes_line);
      blur_pixel_type res;
      int unsigned    acc [NUM_CHAN];
      int             pos;
      int             span;
      span = int'(line_radius);
      for (int c = 0; c < NUM_CHAN; c++) acc[c] = 0;
      for (int k = -span; k <= span; k++) begin
         pos = int'(center) + k;
         if (pos < 0) pos = 0;
         if (pos > int'(count) - 1) pos = int'(count) - 1;
         for (int c = 0; c < NUM_CHAN; c++) acc[c] += line_pixels[pos % STORE_DEPTH][c];
      end
      for (int c = 0; c < NUM_CHAN; c++) res.mean[c] = PIX_W'(acc[c] / (2 * line_radius + 1));
      res.alpha    = ALPHA_VALUE;
      res.line_end = closes_line;
      return res;
   endfunction

   task automatic take_pixel(rgb_type pix, logic end_flag);
      logic        line_done;
      int unsigned ready_upto;
      // Latch the radius on the first pixel of a line.
      if (pixels_in == 0)
         line_radius = (radius_reg > MAX_RADIUS) ? MAX_RADIUS : radius_reg;
      line_pixels[pixels_in % STORE_DEPTH] = pix;
      pixels_in++;
      line_done = end_flag || (pixels_in >= MAX_LINE);
      if (line_done)
         ready_upto = pixels_in;
      else
         ready_upto = (pixels_in > line_radius) ? pixels_in - line_radius : 0;
      while (pixels_out < ready_upto) begin
         blurred_q.insert(blurred_q.size(),
                          window_mean(pixels_out, pixels_in,
                                      line_done && (pixels_out + 1 == pixels_in)));
         pixels_out++;
      end
      if (line_done) begin
         pixels_in  = 0;
         pixels_out = 0;
      end
   endtask

   task automatic check_pixel();
      blur_pixel_type want;
      logic           bad;
      if (blurred_q.size() == 0) begin
         fail_total++;
         if (fail_total <= REPORT_LIMIT)
            $display("%0t: output transfer with none expected: tdata=%h tlast=%b",
                     $time, rsp_tdata, rsp_tlast);
      end else begin
         want = blurred_q.pop_front();
         bad  = (rsp_tdata[7:0] !== want.mean[0]) || (rsp_tdata[15:8] !== want.mean[1]) ||
                (rsp_tdata[23:16] !== want.mean[2]) || (rsp_tdata[31:24] !== want.alpha) ||
                (rsp_tlast !== want.line_end);
         if (bad) begin
            fail_total++;
            if (fail_total <= REPORT_LIMIT)
               $display("%0t: mismatch: exp b g r a %h %h %h %h last %b, got %h %h %h %h %b",
                        $time, want.mean[0], want.mean[1], want.mean[2], want.alpha,
                        want.line_end, rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16],
                        rsp_tdata[31:24], rsp_tlast);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         radius_reg  = RADIUS_RESET;
         line_radius = RADIUS_RESET;
         pixels_in   = 0;
         pixels_out  = 0;
         blurred_q.delete();
      end else begin
         if (csr_wr_en)
            radius_reg = csr_wr_data;
         if (req_tvalid && req_tready)
            take_pixel(rgb_type'(req_tdata), req_tlast);
         if (rsp_tvalid && rsp_tready)
            check_pixel();
      end
      fail_count    <= fail_total;
      pending_count <= blurred_q.size();
   end

endmodule

FILE: dv/line_box_blur_tb.sv
`timescale 1ns / 1ps
// Testbench top for the line box blur: clock, reset, pixel lines, radius writes and verdict.
module line_box_blur_tb;
   import lbb_pkg::*;

   localparam int  MAX_RADIUS       = 31;
   localparam int  MAX_LINE         = 4096;
   localparam int  RESET_CYCLES     = 11;
   localparam int  SETTLE_CYCLES    = 16;
   localparam int  LONG_HOLD_CYCLES = 400;
   localparam int  RANDOM_PIXELS    = 250;
   localparam time TIMEOUT_NS       = 10_000_000;

   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_type;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                csr_wr_en   = 1'b0;
   logic [RADIUS_W-1:0] csr_wr_data = '0;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [23:0]         req_tdata   = '0;    // blue_in, green_in, red_in
   logic                req_tlast   = 1'b0;  // line_end_in
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [31:0]         rsp_tdata;           // blue_out, green_out, red_out, alpha_out
   logic                rsp_tlast;           // line_end_out

   int fail_count;
   int pending_count;
   int burst_left = 0;
   bit long_hold_pending = 1'b0;

   always #5 clock = ~clock;

   line_box_blur #(
      .MAX_RADIUS (MAX_RADIUS),
      .MAX_LINE   (MAX_LINE)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   line_box_blur_checker #(
      .MAX_RADIUS (MAX_RADIUS),
      .MAX_LINE   (MAX_LINE)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   function automatic rgb_type random_pixel();
      rgb_type pix;
      for (int c = 0; c < NUM_CHAN; c++) begin
         case ($urandom_range(0, 9))
            0:       pix[c] = 8'h00;
            1:       pix[c] = 8'hFF;
            default: pix[c] = 8'($urandom_range(0, 255));
         endcase
      end
      return pix;
   endfunction

   // Offer one pixel in bursts with random gaps; return once the transfer happens.
   task automatic send_pixel(rgb_type pix, logic end_flag);
      int gap_cycles;
      @(negedge clock);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         gap_cycles  = $urandom_range(1, 8);
         repeat (gap_cycles) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      req_tlast  <= end_flag;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_line(int length);
      for (int i = 0; i < length; i++)
         send_pixel(random_pixel(), i == length - 1);
   endtask

   // Hold the sender until every predicted output has left and the block has settled.
   task automatic finish_phase();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_radius(logic [RADIUS_W-1:0] value);
      finish_phase();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Output side: stretches of open, coin-flip and sparse ready, plus one long hold.
   initial begin : rsp_side
      rx_mode_type mode;
      int          stretch;
      forever begin
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end
         mode    = rx_mode_type'($urandom_range(0, 2));
         stretch = $urandom_range(8, 64);
         repeat (stretch) begin
            @(negedge clock);
            case (mode)
               RX_OPEN: rsp_tready <= 1'b1;
               RX_COIN: rsp_tready <= 1'($urandom_range(0, 1));
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("** line_box_blur: FAILED **");
      $finish;
   end

   initial begin : stimulus
      int sent;
      int line_len;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Reset radius: a one-pixel line passes through unchanged.
      send_pixel({8'hAB, 8'h00, 8'hFF}, 1'b1);
      // Line shorter than the window, extreme values.
      send_pixel({8'h00, 8'h00, 8'h00}, 1'b0);
      send_pixel({8'hFF, 8'hFF, 8'hFF}, 1'b0);
      send_pixel({8'hFF, 8'h00, 8'hFF}, 1'b1);
      // Radius written mid-line takes effect on the next line only.
      send_pixel({8'h12, 8'h34, 8'h56}, 1'b0);
      send_pixel({8'hFE, 8'h01, 8'h80}, 1'b0);
      set_radius(5'd0);
      send_pixel({8'h7F, 8'hC0, 8'h03}, 1'b0);
      send_pixel({8'h00, 8'hFF, 8'h00}, 1'b0);
      send_pixel({8'hFF, 8'h00, 8'h00}, 1'b1);
      // Radius zero: outputs equal inputs.
      send_pixel({8'h01, 8'h02, 8'h04}, 1'b0);
      send_pixel({8'h08, 8'h10, 8'h20}, 1'b0);
      send_pixel({8'h40, 8'h80, 8'hFF}, 1'b0);
      send_pixel({8'hAA, 8'h55, 8'hAA}, 1'b1);
      // Largest radius on a short line.
      set_radius(5'd31);
      send_pixel({8'hFF, 8'hFF, 8'hFF}, 1'b0);
      send_pixel({8'hFF, 8'hFF, 8'hFF}, 1'b0);
      send_pixel({8'h00, 8'h00, 8'h00}, 1'b0);
      send_pixel({8'h55, 8'hAA, 8'h55}, 1'b0);
      send_pixel({8'h00, 8'h00, 8'h01}, 1'b1);

      // Random lines; the receiver holds off during the first one so the block backs up.
      long_hold_pending = 1'b1;
      send_line(80);
      sent = 80;
      while (sent < RANDOM_PIXELS) begin
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 4))
               0:       set_radius(5'd0);
               1:       set_radius(5'd31);
               default: set_radius(RADIUS_W'($urandom_range(0, 31)));
            endcase
         end
         line_len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 100)
                                                : $urandom_range(1, 40);
         send_line(line_len);
         sent += line_len;
      end

      finish_phase();
      if (fail_count == 0)
         $display("** line_box_blur: PASSED **");
      else
         $display("** line_box_blur: FAILED **");
      $finish;
   end

endmodule
